### sv/wnws_pkg.sv
`timescale 1ns / 1ps

package wnws_pkg;

  // Default table depth.
  localparam int unsigned MAX_POINTS_DEF = 1024;

  // Fixed field widths.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned COORD_W    = 24;
  localparam int unsigned SLOT_W     = 10;
  localparam int unsigned CNT_CFG_W  = 11;
  localparam int unsigned DIST_W     = 32;

  // Input function codes.
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_WINDOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NO_MATCH_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOST_THRESHOLD = 3'd4;

  // Register reset values.
  localparam logic [CNT_CFG_W-1:0] SEARCH_WINDOW_RST  = 11'd200;
  localparam logic [DIST_W-1:0]    NO_MATCH_LIMIT_RST = 32'd655360000;
  localparam logic [DIST_W-1:0]    LOST_THRESHOLD_RST = 32'd589824000;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // write the input word into the table
    logic query;   // latch the position and set up the walk
    logic reduce;  // subtract the point count from the walk index
    logic issue;   // read one table entry into the distance pipeline
    logic finish;  // publish the result and update the tracking state
  } wnws_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic rem_zero;   // no points left to examine
    logic last_step;  // exactly one point left
    logic idx_over;   // loop mode and the walk index lies beyond the path
    logic pipe_busy;  // distance pipeline still holds points
    logic out_busy;   // the output register holds a word not yet taken
  } wnws_sts_t;

endpackage

### sv/wnws_ctrl.sv
`timescale 1ns / 1ps

module wnws_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                func_i,
  output logic                in_stall_o,
  input  wnws_pkg::wnws_sts_t sts_i,
  output wnws_pkg::wnws_cmd_t cmd_o
);
  import wnws_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_WRAP  = 5'b00010,
    ST_RUN   = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (func_i == FUNC_QUERY) begin
            cmd_o.query = 1'b1;
            state_d     = ST_WRAP;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      ST_WRAP: begin
        // A start index left beyond a shortened closed path is brought back in range.
        if (sts_i.idx_over) begin
          cmd_o.reduce = 1'b1;
        end else begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd_o.issue = !sts_i.rem_zero;
        if (sts_i.rem_zero || sts_i.last_step) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts_i.pipe_busy) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

### sv/wnws_datapath.sv
`timescale 1ns / 1ps

module wnws_datapath #(
  parameter int unsigned MAX_POINTS = wnws_pkg::MAX_POINTS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [wnws_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [wnws_pkg::CFG_DATA_W-1:0]        cfg_wdata_i,
  input  logic [wnws_pkg::SLOT_W-1:0]            point_index_i,
  input  logic signed [wnws_pkg::COORD_W-1:0]    pos_x_i,
  input  logic signed [wnws_pkg::COORD_W-1:0]    pos_y_i,
  input  logic                                   out_stall_i,
  output logic                                   out_valid_o,
  output logic [wnws_pkg::SLOT_W-1:0]            nearest_index_o,
  output logic [wnws_pkg::DIST_W-1:0]            nearest_sqr_distance_o,
  output logic                                   lost_flag_o,
  input  wnws_pkg::wnws_cmd_t                    cmd_i,
  output wnws_pkg::wnws_sts_t                    sts_o
);
  import wnws_pkg::*;

  localparam int unsigned IW = $clog2(MAX_POINTS);
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned SW = (CW > CNT_CFG_W) ? CW : CNT_CFG_W;
  localparam int unsigned EW = 2 * COORD_W;
  localparam int unsigned AW = COORD_W;
  localparam int unsigned QW = 2 * AW;
  localparam int unsigned SUMW = QW + 1;

  // Configuration registers.
  logic                 loop_mode_q;
  logic [CNT_CFG_W-1:0] point_count_q;
  logic [CNT_CFG_W-1:0] search_window_q;
  logic [DIST_W-1:0]    no_match_limit_q;
  logic [DIST_W-1:0]    lost_threshold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loop_mode_q      <= 1'b0;
      point_count_q    <= '0;
      search_window_q  <= SEARCH_WINDOW_RST;
      no_match_limit_q <= NO_MATCH_LIMIT_RST;
      lost_threshold_q <= LOST_THRESHOLD_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_LOOP_MODE:      loop_mode_q      <= cfg_wdata_i[0];
        REG_POINT_COUNT:    point_count_q    <= cfg_wdata_i[CNT_CFG_W-1:0];
        REG_SEARCH_WINDOW:  search_window_q  <= cfg_wdata_i[CNT_CFG_W-1:0];
        REG_NO_MATCH_LIMIT: no_match_limit_q <= cfg_wdata_i;
        REG_LOST_THRESHOLD: lost_threshold_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Point count clipped to the table depth.
  logic [CW-1:0] count;
  assign count = (32'(point_count_q) > 32'(MAX_POINTS)) ? CW'(MAX_POINTS)
                                                       : CW'(point_count_q);

  // Waypoint table, x in the upper half and y in the lower half.
  logic [EW-1:0] mem_q [MAX_POINTS];
  logic [EW-1:0] rd_q;
  logic [IW-1:0] idx_q;
  logic          load_ok;

  assign load_ok = (32'(point_index_i) < 32'(MAX_POINTS));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && load_ok) begin
      mem_q[IW'(point_index_i)] <= {pos_x_i, pos_y_i};
    end
    if (cmd_i.issue) begin
      rd_q <= mem_q[idx_q];
    end
  end

  // Tracking state and walk control.
  logic [IW-1:0] window_start_q;
  logic          search_all_q;
  logic [SW-1:0] rem_q, rem_d;
  logic [IW-1:0] idx_d;
  logic signed [COORD_W-1:0] px_q, py_q;

  always_comb begin
    rem_d = rem_q;
    idx_d = idx_q;
    if (cmd_i.query) begin
      if (search_all_q) begin
        idx_d = '0;
        rem_d = SW'(count);
      end else begin
        idx_d = window_start_q;
        if (loop_mode_q) begin
          rem_d = (count != '0) ? SW'(search_window_q) : '0;
        end else if (SW'(window_start_q) >= SW'(count)) begin
          rem_d = '0;
        end else if ((SW'(count) - SW'(window_start_q)) > SW'(search_window_q)) begin
          rem_d = SW'(search_window_q);
        end else begin
          rem_d = SW'(count) - SW'(window_start_q);
        end
      end
    end else if (cmd_i.reduce) begin
      idx_d = IW'(SW'(idx_q) - SW'(count));
    end else if (cmd_i.issue) begin
      rem_d = rem_q - SW'(1);
      if (loop_mode_q && (SW'(idx_q) + SW'(1) == SW'(count))) begin
        idx_d = '0;
      end else begin
        idx_d = idx_q + IW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      idx_q <= '0;
    end else begin
      rem_q <= rem_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.query) begin
      px_q <= pos_x_i;
      py_q <= pos_y_i;
    end
  end

  // Distance pipeline: table read, absolute differences, squares, sum and compare.
  logic          v1_q, v2_q, v3_q;
  logic [IW-1:0] i1_q, i2_q, i3_q;
  logic [AW-1:0] dx_q, dy_q;
  logic [QW-1:0] sqx_q, sqy_q;
  logic signed [COORD_W:0] diff_x, diff_y;
  logic [COORD_W:0]        neg_x, neg_y;
  logic [QW-1:0]           prod_x, prod_y;
  logic [SUMW-1:0]         sum_sq;
  logic [DIST_W-1:0]       best_q;
  logic [IW-1:0]           best_idx_q;

  assign diff_x = $signed({rd_q[EW-1], rd_q[EW-1:COORD_W]}) - $signed({px_q[COORD_W-1], px_q});
  assign diff_y = $signed({rd_q[COORD_W-1], rd_q[COORD_W-1:0]})
                - $signed({py_q[COORD_W-1], py_q});
  assign neg_x  = -diff_x;
  assign neg_y  = -diff_y;
  assign prod_x = dx_q * dx_q;
  assign prod_y = dy_q * dy_q;
  assign sum_sq = SUMW'(sqx_q) + SUMW'(sqy_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    i1_q  <= idx_q;
    i2_q  <= i1_q;
    i3_q  <= i2_q;
    dx_q  <= diff_x[COORD_W] ? AW'(neg_x) : AW'(diff_x);
    dy_q  <= diff_y[COORD_W] ? AW'(neg_y) : AW'(diff_y);
    sqx_q <= prod_x;
    sqy_q <= prod_y;
    if (cmd_i.query) begin
      best_q     <= no_match_limit_q;
      best_idx_q <= '0;
    end else if (v3_q && (sum_sq < SUMW'(best_q))) begin
      // Strictly smaller only, so the first point examined wins a tie.
      best_q     <= DIST_W'(sum_sq);
      best_idx_q <= i3_q;
    end
  end

  // Tracking state update and output register.
  logic lost;
  assign lost = (best_q >= lost_threshold_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_start_q <= '0;
      search_all_q   <= 1'b1;
      out_valid_o    <= 1'b0;
    end else begin
      if (cmd_i.query) begin
        search_all_q <= 1'b0;
      end else if (cmd_i.finish) begin
        search_all_q   <= lost;
        window_start_q <= best_idx_q;
      end
      if (cmd_i.finish) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      nearest_index_o        <= SLOT_W'(best_idx_q);
      nearest_sqr_distance_o <= best_q;
      lost_flag_o            <= lost;
    end
  end

  assign sts_o.rem_zero  = (rem_q == '0);
  assign sts_o.last_step = (rem_q == SW'(1));
  assign sts_o.idx_over  = loop_mode_q && (rem_q != '0) && (SW'(idx_q) >= SW'(count));
  assign sts_o.pipe_busy = v1_q || v2_q || v3_q;
  assign sts_o.out_busy  = out_valid_o && out_stall_i;

endmodule

### sv/windowed_nearest_waypoint_search.sv
`timescale 1ns / 1ps

// Channel   Handshake                Word
// --------  -----------------------  --------------------------------------------------
// input     in_valid_i / in_stall_o  func_i, point_index_i, pos_x_i, pos_y_i
// output    out_valid_o/ out_stall_i nearest_index_o, nearest_sqr_distance_o, lost_flag_o
// config    cfg_we_i                 cfg_index_i, cfg_wdata_i
//
// A load word is written into the table as it is taken, and the input stays ready.
// A query examines the whole path or the search window, which may hold no point;
// the input is ready again in the cycle the result appears. One table entry is
// read per cycle through the single read port of the waypoint memory.
// A closed-path query whose start index lies beyond a shortened path first
// subtracts the point count from it until it is in range, before the walk begins.
// Reset clears all control state; the waypoint table holds no reset value.
// A stalled result is held, and a query that finishes meanwhile waits for it.

module windowed_nearest_waypoint_search #(
  parameter int unsigned MAX_POINTS = wnws_pkg::MAX_POINTS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [wnws_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [wnws_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                func_i,
  input  logic [wnws_pkg::SLOT_W-1:0]         point_index_i,
  input  logic signed [wnws_pkg::COORD_W-1:0] pos_x_i,
  input  logic signed [wnws_pkg::COORD_W-1:0] pos_y_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [wnws_pkg::SLOT_W-1:0]         nearest_index_o,
  output logic [wnws_pkg::DIST_W-1:0]         nearest_sqr_distance_o,
  output logic                                lost_flag_o
);
  import wnws_pkg::*;

  // The controller sequences each word; the datapath owns the table, the
  // configuration registers, the distance pipeline and the result register.
  wnws_cmd_t cmd;
  wnws_sts_t sts;

  wnws_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .func_i     (func_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  wnws_datapath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_datapath (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cfg_we_i               (cfg_we_i),
    .cfg_index_i            (cfg_index_i),
    .cfg_wdata_i            (cfg_wdata_i),
    .point_index_i          (point_index_i),
    .pos_x_i                (pos_x_i),
    .pos_y_i                (pos_y_i),
    .out_stall_i            (out_stall_i),
    .out_valid_o            (out_valid_o),
    .nearest_index_o        (nearest_index_o),
    .nearest_sqr_distance_o (nearest_sqr_distance_o),
    .lost_flag_o            (lost_flag_o),
    .cmd_i                  (cmd),
    .sts_o                  (sts)
  );

endmodule

### sv/wnws_checker.sv
`timescale 1ns / 1ps

module wnws_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                func_i,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic [wnws_pkg::SLOT_W-1:0]         nearest_index_o,
  input logic [wnws_pkg::DIST_W-1:0]         nearest_sqr_distance_o
);
  import wnws_pkg::*;

  // A query occupies the block on the following cycle.
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (func_i == FUNC_QUERY) |=> in_stall_o)
    else $error("input ready right after a query word");

  // A load completes in the cycle it is taken.
  a_load_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (func_i == FUNC_LOAD) |=> !in_stall_o)
    else $error("input stalled after a load word");

  // A query cannot produce its result in the cycle after it is taken.
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (func_i == FUNC_QUERY) && !out_valid_o
    |=> !out_valid_o)
    else $error("result appeared one cycle after a query");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(nearest_index_o)
      && $stable(nearest_sqr_distance_o))
    else $error("stalled result word changed");

endmodule

bind windowed_nearest_waypoint_search wnws_checker u_wnws_checker (.*);

### sim/windowed_nearest_waypoint_search_tb.sv
`timescale 1ns / 1ps

module windowed_nearest_waypoint_search_tb;

  localparam int unsigned MAX_PTS      = wnws_pkg::MAX_POINTS_DEF;
  localparam int unsigned COORD_W      = wnws_pkg::COORD_W;
  localparam int unsigned SLOT_W       = wnws_pkg::SLOT_W;
  localparam int unsigned DIST_W       = wnws_pkg::DIST_W;
  localparam int          CLK_PERIOD   = 10;
  localparam int          RESET_CYCLES = 10;
  // A load is absorbed as soon as it is taken, so a short quiet spell after the
  // last answer is enough before the registers may change.
  localparam int          SETTLE       = 16;
  localparam int unsigned ITEM_TARGET  = 400;
  // Worst case is roughly 450 words, each with up to a 1024-point window plus
  // wrap subtractions, stalls and gaps; this timeout is several times that.
  localparam int          TIMEOUT_NS   = 20_000_000;

  // One answer word as the block reports it.
  typedef struct packed {
    logic [SLOT_W-1:0] index;
    logic [DIST_W-1:0] sqr_dist;
    logic              lost;
  } answer_t;

  // Keeps its own copy of the waypoint table, the tracking state and the
  // registers, works out the answer of every accepted query, and checks the
  // answers coming out of the block in order.
  class nearest_waypoint_board;
    bit signed [COORD_W-1:0]        wp_x [MAX_PTS];
    bit signed [COORD_W-1:0]        wp_y [MAX_PTS];
    bit [SLOT_W-1:0]                win_start;
    bit                             full_search;
    bit                             loop_mode;
    bit [wnws_pkg::CNT_CFG_W-1:0]   point_count;
    bit [wnws_pkg::CNT_CFG_W-1:0]   search_window;
    bit [DIST_W-1:0]                no_match_limit;
    bit [DIST_W-1:0]                lost_threshold;
    answer_t                        expected_nearest[$];
    int unsigned                    errors;
    int unsigned                    queries;
    int unsigned                    loads;

    function new();
      win_start      = '0;
      full_search    = 1'b1;
      loop_mode      = 1'b0;
      point_count    = '0;
      search_window  = wnws_pkg::SEARCH_WINDOW_RST;
      no_match_limit = wnws_pkg::NO_MATCH_LIMIT_RST;
      lost_threshold = wnws_pkg::LOST_THRESHOLD_RST;
      errors         = 0;
      queries        = 0;
      loads          = 0;
    endfunction

    function void set_reg(input logic [wnws_pkg::CFG_IDX_W-1:0] idx,
                          input logic [wnws_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        wnws_pkg::REG_LOOP_MODE:      loop_mode      = data[0];
        wnws_pkg::REG_POINT_COUNT:    point_count    = data[wnws_pkg::CNT_CFG_W-1:0];
        wnws_pkg::REG_SEARCH_WINDOW:  search_window  = data[wnws_pkg::CNT_CFG_W-1:0];
        wnws_pkg::REG_NO_MATCH_LIMIT: no_match_limit = data;
        wnws_pkg::REG_LOST_THRESHOLD: lost_threshold = data;
        default: ;
      endcase
    endfunction

    // Walks the whole path or the window from the last hit and returns the
    // closest point; distances are kept exact in 64 bits.
    function answer_t search_nearest(input logic signed [COORD_W-1:0] px,
                                     input logic signed [COORD_W-1:0] py);
      int unsigned n;
      int unsigned first;
      int unsigned steps;
      int unsigned slot;
      int unsigned best_idx;
      longint      best;
      longint      dx;
      longint      dy;
      longint      d;
      answer_t     a;
      n = (point_count > MAX_PTS) ? MAX_PTS : point_count;
      if (full_search) begin
        first       = 0;
        steps       = n;
        full_search = 1'b0;
      end else begin
        first = win_start;
        if (loop_mode) begin
          steps = (n != 0) ? search_window : 0;
        end else if (first >= n) begin
          steps = 0;
        end else begin
          steps = n - first;
          if (steps > search_window) steps = search_window;
        end
      end
      best     = longint'(no_match_limit);
      best_idx = 0;
      for (int unsigned i = 0; i < steps; i++) begin
        slot = loop_mode ? (i + first) % n : i + first;
        if (slot < MAX_PTS) begin
          dx = longint'(wp_x[slot]) - longint'(px);
          dy = longint'(wp_y[slot]) - longint'(py);
          d  = dx * dx + dy * dy;
          // Strictly smaller only, so on a tie the first point examined stays.
          if (d < best) begin
            best     = d;
            best_idx = slot;
          end
        end
      end
      if (best >= longint'(lost_threshold)) full_search = 1'b1;
      win_start  = best_idx[SLOT_W-1:0];
      a.index    = best_idx[SLOT_W-1:0];
      a.sqr_dist = best[DIST_W-1:0];
      a.lost     = full_search;
      return a;
    endfunction

    // Called for every word the block accepts on its input.
    function void take_word(input logic f, input logic [SLOT_W-1:0] slot,
                            input logic signed [COORD_W-1:0] x,
                            input logic signed [COORD_W-1:0] y);
      if (f == wnws_pkg::FUNC_LOAD) begin
        wp_x[slot] = x;
        wp_y[slot] = y;
        loads++;
      end else begin
        expected_nearest.insert(expected_nearest.size(), search_nearest(x, y));
        queries++;
      end
    endfunction

    // Called for every word the block hands over on its output.
    function void match_answer(input logic [SLOT_W-1:0] index,
                               input logic [DIST_W-1:0] sqr_dist,
                               input logic lost);
      answer_t e;
      if (expected_nearest.size() == 0) begin
        $error("unexpected answer word: nearest_index %0d, %s %0d, lost_flag %0b",
               index, "nearest_sqr_distance", sqr_dist, lost);
        errors++;
        return;
      end
      e = expected_nearest.pop_front();
      if (index !== e.index) begin
        $error("nearest_index: expected %0d, got %0d", e.index, index);
        errors++;
      end
      if (sqr_dist !== e.sqr_dist) begin
        $error("nearest_sqr_distance: expected %0d, got %0d", e.sqr_dist, sqr_dist);
        errors++;
      end
      if (lost !== e.lost) begin
        $error("lost_flag: expected %0b, got %0b", e.lost, lost);
        errors++;
      end
    endfunction

    function int pending();
      return expected_nearest.size();
    endfunction
  endclass

  // All inputs of the block start at known values.
  logic                                clk_i         = 1'b0;
  logic                                rst_ni        = 1'b0;
  logic                                cfg_we_i      = 1'b0;
  logic [wnws_pkg::CFG_IDX_W-1:0]      cfg_index_i   = '0;
  logic [wnws_pkg::CFG_DATA_W-1:0]     cfg_wdata_i   = '0;
  logic                                in_valid_i    = 1'b0;
  logic                                in_stall_o;
  logic                                func_i        = wnws_pkg::FUNC_LOAD;
  logic [SLOT_W-1:0]                   point_index_i = '0;
  logic signed [COORD_W-1:0]           pos_x_i       = '0;
  logic signed [COORD_W-1:0]           pos_y_i       = '0;
  logic                                out_valid_o;
  logic                                out_stall_i   = 1'b0;
  logic [SLOT_W-1:0]                   nearest_index_o;
  logic [DIST_W-1:0]                   nearest_sqr_distance_o;
  logic                                lost_flag_o;

  nearest_waypoint_board board = new();

  // Idle limits for the two sides; a phase sets them to 0 for a stretch of
  // back-to-back traffic or to 9 for random gaps and stalls.
  int unsigned tx_max_gap = 9;
  int unsigned rx_max_gap = 9;
  int unsigned rx_hold    = 0;

  // The stimulus side keeps its own idea of the path so that queries can
  // follow it the way a vehicle would.
  logic signed [COORD_W-1:0] path_x [MAX_PTS];
  logic signed [COORD_W-1:0] path_y [MAX_PTS];
  int unsigned path_len     = 0;
  int unsigned cursor       = 0;
  int unsigned sent_words   = 0;
  int unsigned phase_count  = 0;

  windowed_nearest_waypoint_search DUT (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cfg_we_i               (cfg_we_i),
    .cfg_index_i            (cfg_index_i),
    .cfg_wdata_i            (cfg_wdata_i),
    .in_valid_i             (in_valid_i),
    .in_stall_o             (in_stall_o),
    .func_i                 (func_i),
    .point_index_i          (point_index_i),
    .pos_x_i                (pos_x_i),
    .pos_y_i                (pos_y_i),
    .out_valid_o            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .nearest_index_o        (nearest_index_o),
    .nearest_sqr_distance_o (nearest_sqr_distance_o),
    .lost_flag_o            (lost_flag_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Output side: after every word taken, the receiver stalls for a freshly
  // drawn number of cycles. The stall changes only at falling edges.
  always @(negedge clk_i) begin
    if (rx_hold != 0) begin
      out_stall_i <= 1'b1;
      rx_hold--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // A word is taken at a rising edge with valid high and stall low. Values
  // read here are the ones from before the edge, as the block sees them.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.match_answer(nearest_index_o, nearest_sqr_distance_o, lost_flag_o);
      rx_hold = $urandom_range(0, rx_max_gap);
    end
  end

  // Offers one input word after a random gap and holds it until the block
  // takes it. Valid stays high when the next word follows with no gap.
  task automatic send_word(input logic f, input logic [SLOT_W-1:0] slot,
                           input logic signed [COORD_W-1:0] x,
                           input logic signed [COORD_W-1:0] y);
    int unsigned gap;
    gap = $urandom_range(0, tx_max_gap);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    func_i        <= f;
    point_index_i <= slot;
    pos_x_i       <= x;
    pos_y_i       <= y;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.take_word(f, slot, x, y);
    sent_words++;
  endtask

  // Drops valid and waits until every query has been answered, then waits out
  // the given settle time so that a trailing load has surely landed.
  task automatic pause_for_answers(input int settle);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // Register writes only happen while the block has nothing in flight.
  task automatic program_reg(input logic [wnws_pkg::CFG_IDX_W-1:0] idx,
                             input logic [wnws_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    board.set_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic signed [COORD_W-1:0] jitter(input logic signed [COORD_W-1:0] v,
                                                       input int amp);
    int t;
    t = int'(v) + int'($urandom_range(0, 2 * amp)) - amp;
    return t[COORD_W-1:0];
  endfunction

  // Loads slots 0..n-1 with a random walk: neighbors lie within 16 m, and
  // the whole path stays inside the coordinate range.
  task automatic load_path(input int unsigned n);
    int px;
    int py;
    px = int'($urandom_range(0, 4194304)) - 2097152;
    py = int'($urandom_range(0, 4194304)) - 2097152;
    for (int unsigned i = 0; i < n; i++) begin
      path_x[i] = px[COORD_W-1:0];
      path_y[i] = py[COORD_W-1:0];
      send_word(wnws_pkg::FUNC_LOAD, i[SLOT_W-1:0], path_x[i], path_y[i]);
      px += int'($urandom_range(0, 8192)) - 4096;
      py += int'($urandom_range(0, 8192)) - 4096;
    end
    path_len = n;
  endtask

  // Most queries follow the path a step or two at a time, some jump to
  // another point on it, and the rest land anywhere in the coordinate range.
  task automatic send_query_word();
    int unsigned               r;
    logic [SLOT_W-1:0]         junk;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    junk = SLOT_W'($urandom);
    r    = $urandom_range(0, 99);
    if (path_len == 0 || r >= 85) begin
      x = COORD_W'($urandom);
      y = COORD_W'($urandom);
    end else begin
      if (r >= 70) cursor = $urandom_range(0, path_len - 1);
      else cursor = (cursor + $urandom_range(0, 2)) % path_len;
      x = jitter(path_x[cursor], 1024);
      y = jitter(path_y[cursor], 1024);
    end
    send_word(wnws_pkg::FUNC_QUERY, junk, x, y);
  endtask

  // Half of the loads nudge a point of the path, the other half write any
  // slot with any coordinates.
  task automatic send_load_word();
    logic [SLOT_W-1:0]         slot;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    if (path_len != 0 && $urandom_range(0, 1) == 1) begin
      slot         = SLOT_W'($urandom_range(0, path_len - 1));
      path_x[slot] = jitter(path_x[slot], 512);
      path_y[slot] = jitter(path_y[slot], 512);
      x            = path_x[slot];
      y            = path_y[slot];
    end else begin
      slot = SLOT_W'($urandom);
      x    = COORD_W'($urandom);
      y    = COORD_W'($urandom);
    end
    send_word(wnws_pkg::FUNC_LOAD, slot, x, y);
  endtask

  // One setting of all five registers followed by a burst of traffic. Every
  // slot a query can reach is loaded before the first query of the phase.
  // The phase ends on a query at the last point, so that the next phase may
  // start with the window beyond a shorter path.
  task automatic run_phase(input bit loop, input int unsigned count,
                           input int unsigned window, input logic [DIST_W-1:0] limit,
                           input logic [DIST_W-1:0] lost_thr,
                           input int unsigned words, input bit fresh);
    int unsigned n;
    pause_for_answers(SETTLE);
    program_reg(wnws_pkg::REG_LOOP_MODE, {31'b0, loop});
    program_reg(wnws_pkg::REG_POINT_COUNT, count);
    program_reg(wnws_pkg::REG_SEARCH_WINDOW, window);
    program_reg(wnws_pkg::REG_NO_MATCH_LIMIT, limit);
    program_reg(wnws_pkg::REG_LOST_THRESHOLD, lost_thr);
    phase_count++;
    n = (count > MAX_PTS) ? MAX_PTS : count;
    if (fresh) load_path(n);
    tx_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 9;
    rx_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 9;
    cursor     = 0;
    for (int unsigned k = 0; k < words; k++) begin
      // Now and then, and always halfway, the sender holds off until the
      // block has answered everything.
      if (k == words / 2 || $urandom_range(0, 29) == 0) pause_for_answers(0);
      if ($urandom_range(0, 99) < 15) send_load_word();
      else send_query_word();
    end
    if (n != 0) send_word(wnws_pkg::FUNC_QUERY, '0, path_x[n-1], path_y[n-1]);
  endtask

  initial begin : stimulus
    int unsigned      count;
    int unsigned      window;
    int unsigned      r;
    logic [DIST_W-1:0] limit;
    logic [DIST_W-1:0] lost_thr;

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed words under the reset register values. With an empty path the
    // first query examines nothing and reports the no-match limit.
    send_word(wnws_pkg::FUNC_QUERY, '0, '0, '0);
    send_word(wnws_pkg::FUNC_LOAD, 10'd0, 24'sh800000, 24'sh800000);
    send_word(wnws_pkg::FUNC_LOAD, 10'd1, 24'sh7FFFFF, 24'sh7FFFFF);
    // Slots 2 and 3 hold the same point; the lower index must win the tie.
    send_word(wnws_pkg::FUNC_LOAD, 10'd2, '0, '0);
    send_word(wnws_pkg::FUNC_LOAD, 10'd3, '0, '0);
    send_word(wnws_pkg::FUNC_LOAD, 10'd4, 24'sd256, -24'sd256);
    send_word(wnws_pkg::FUNC_LOAD, 10'd1023, -24'sd1, 24'sd1);
    pause_for_answers(SETTLE);
    program_reg(wnws_pkg::REG_POINT_COUNT, 32'd5);
    // Full search finds the tie at the origin, then a far corner misses the
    // clipped window and marks the block lost, which forces full searches.
    send_word(wnws_pkg::FUNC_QUERY, '0, '0, '0);
    send_word(wnws_pkg::FUNC_QUERY, '0, 24'sh7FFFFF, 24'sh7FFFFF);
    send_word(wnws_pkg::FUNC_QUERY, '0, 24'sh7FFFFF, 24'sh7FFFFF);
    send_word(wnws_pkg::FUNC_QUERY, '0, 24'sh800000, 24'sh800000);
    send_word(wnws_pkg::FUNC_QUERY, '0, 24'sh800000, 24'sh800000);
    send_word(wnws_pkg::FUNC_QUERY, '0, 24'sd255, -24'sd255);

    // Fixed settings: open and closed paths, windows of zero, one and more
    // than the path, a start beyond a shortened path and both threshold
    // extremes.
    run_phase(1'b0, 16, 200, wnws_pkg::NO_MATCH_LIMIT_RST,
              wnws_pkg::LOST_THRESHOLD_RST, 40, 1'b1);
    run_phase(1'b1, 16, 5, wnws_pkg::NO_MATCH_LIMIT_RST,
              wnws_pkg::LOST_THRESHOLD_RST, 40, 1'b1);
    run_phase(1'b1, 5, 1024, wnws_pkg::NO_MATCH_LIMIT_RST,
              wnws_pkg::LOST_THRESHOLD_RST, 30, 1'b1);
    run_phase(1'b0, 1, 1, wnws_pkg::NO_MATCH_LIMIT_RST,
              wnws_pkg::LOST_THRESHOLD_RST, 20, 1'b1);
    run_phase(1'b1, 8, 0, wnws_pkg::NO_MATCH_LIMIT_RST,
              wnws_pkg::LOST_THRESHOLD_RST, 15, 1'b1);
    run_phase(1'b0, 12, 4, '0, '0, 10, 1'b1);
    run_phase(1'b0, 40, 3, '1, '1, 20, 1'b1);

    // Random settings, mostly short paths with windows around the path
    // length, until enough words have gone in.
    while (sent_words < ITEM_TARGET) begin
      r     = $urandom_range(0, 9);
      count = (r == 0) ? 0 : $urandom_range(1, 48);
      r     = $urandom_range(0, 9);
      if (r == 0) window = 0;
      else if (r == 1) window = $urandom_range(count, 1024);
      else window = $urandom_range(1, count + 4);
      r = $urandom_range(0, 9);
      if (r <= 5) limit = wnws_pkg::NO_MATCH_LIMIT_RST;
      else if (r <= 7) limit = $urandom_range(100000, 20000000);
      else if (r == 8) limit = $urandom;
      else limit = ($urandom_range(0, 1) == 1) ? '1 : '0;
      r = $urandom_range(0, 9);
      if (r <= 5) lost_thr = wnws_pkg::LOST_THRESHOLD_RST;
      else if (r <= 7) lost_thr = $urandom_range(50000, 10000000);
      else lost_thr = $urandom;
      run_phase($urandom_range(0, 1), count, window, limit, lost_thr,
                $urandom_range(15, 35), 1'b1);
    end

    pause_for_answers(SETTLE);
    $display("Ran %0d queries and %0d table loads across %0d register settings.",
             board.queries, board.loads, phase_count);
    $display("Paths ranged from empty to 48 points; windows from zero to wrapping.");
    if (board.errors == 0 && board.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("FAILED: results differ");
    $finish;
  end

endmodule

### files.f
sv/wnws_pkg.sv
sv/wnws_ctrl.sv
sv/wnws_datapath.sv
sv/windowed_nearest_waypoint_search.sv
sv/wnws_checker.sv
sim/windowed_nearest_waypoint_search_tb.sv
